// ===== rtl/core/aging_page_replacement_defines.svh =====
// ----------------------------------------------------------------------------
// aging_page_replacement_defines.svh
// Assertion macros used by apr_ctrl in the aging page replacement RTL.
// ----------------------------------------------------------------------------
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define APR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define APR_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/apr_pkg.sv =====
// ----------------------------------------------------------------------------
// apr_pkg
// Fixed field widths and controller state type for aging page replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package apr_pkg;

   localparam int PAGE_W  = 8;
   localparam int FRAME_W = 3;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/aging_page_replacement.sv =====
// ----------------------------------------------------------------------------
// aging_page_replacement
// Aging page replacement over NUM_FRAMES page frames. Each accepted page
// access travels down a chain of frame cells, one cell per cycle, collecting
// the hit frame, the highest empty frame and the oldest frame on its way;
// once it has left the last cell and the output register is free or
// draining, the chosen frame is written and all age counters take their
// aging tick together. The next access is taken right after the update.
// The result sits in an output register, so a stalled result does not
// block the next access, only the commit of that access. Page zero leaves
// the frames untouched, still ages them, and returns all-zero fields.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_page_replacement #(
   parameter int NUM_FRAMES = 8,
   parameter int AGE_BITS   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_page,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_hit,
   output logic             rsp_fault,
   output logic [2:0]       rsp_frame,
   output logic             rsp_evicted_valid,
   output logic [7:0]       rsp_evicted_page
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int TOK_W = apr_pkg::PAGE_W*2 + AGE_BITS + 3*IDX_W + 4;
   localparam int UPD_W = apr_pkg::PAGE_W + IDX_W + 4;

   logic [TOK_W-1:0] tok [NUM_FRAMES+1];
   logic [UPD_W-1:0] upd;

   apr_ctrl #(
      .NUM_FRAMES (NUM_FRAMES),
      .AGE_BITS   (AGE_BITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_fault         (rsp_fault),
      .rsp_frame         (rsp_frame),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .tok_first         (tok[0]),
      .tok_last          (tok[NUM_FRAMES]),
      .upd               (upd)
   );

   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
      apr_cell #(
         .NUM_FRAMES (NUM_FRAMES),
         .AGE_BITS   (AGE_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1]),
         .upd     (upd)
      );
   end

endmodule

`default_nettype wire

// ===== rtl/core/apr_cell.sv =====
// ----------------------------------------------------------------------------
// apr_cell
// One page frame: holds its page and age counter, folds its own entry into
// the search record passing by, and applies the update plus aging tick.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_cell #(
   parameter int NUM_FRAMES = 8,
   parameter int AGE_BITS   = 8,
   parameter int INDEX      = 0
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [apr_pkg::PAGE_W*2+AGE_BITS+3*$clog2(NUM_FRAMES)+3:0] tok_in,
   output wire logic [apr_pkg::PAGE_W*2+AGE_BITS+3*$clog2(NUM_FRAMES)+3:0] tok_out,
   input  wire logic [apr_pkg::PAGE_W+$clog2(NUM_FRAMES)+3:0]             upd
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   typedef struct packed {
      logic                      valid;
      logic [apr_pkg::PAGE_W-1:0] page;
      logic                      hit;
      logic [IDX_W-1:0]          hit_idx;
      logic                      empty;
      logic [IDX_W-1:0]          empty_idx;
      logic                      old;
      logic [AGE_BITS-1:0]       old_age;
      logic [IDX_W-1:0]          old_idx;
      logic [apr_pkg::PAGE_W-1:0] old_page;
   } tok_type;

   typedef struct packed {
      logic                      shift;
      logic                      commit;
      logic                      fill;
      logic                      mark;
      logic [IDX_W-1:0]          target;
      logic [apr_pkg::PAGE_W-1:0] page;
   } upd_type;

   tok_type                    tok_cur;
   tok_type                    tok_in_w;
   tok_type                    tok_ff;
   upd_type                    ctl;
   logic [apr_pkg::PAGE_W-1:0] page_ff;
   logic [apr_pkg::PAGE_W-1:0] page_in;
   logic [AGE_BITS-1:0]        age_ff;
   logic [AGE_BITS-1:0]        age_in;
   logic [AGE_BITS-1:0]        age_base;
   logic                       sel;
   logic                       ref_now;

   assign tok_cur = tok_in;
   assign ctl     = upd;
   assign tok_out = tok_ff;

   // Empty frames take no part in the hit or oldest search.
   always_comb begin
      tok_in_w = tok_cur;
      if (page_ff == '0) begin
         tok_in_w.empty     = 1'b1;
         tok_in_w.empty_idx = MY_IDX;
      end else begin
         if (!tok_cur.old || (age_ff < tok_cur.old_age)) begin
            tok_in_w.old      = 1'b1;
            tok_in_w.old_age  = age_ff;
            tok_in_w.old_idx  = MY_IDX;
            tok_in_w.old_page = page_ff;
         end
         if (page_ff == tok_cur.page) begin
            tok_in_w.hit     = 1'b1;
            tok_in_w.hit_idx = MY_IDX;
         end
      end
   end

   // The referenced bit lives only inside one access: set and shifted in
   // during the same commit, so it is always clear between accesses.
   always_comb begin
      sel      = (ctl.target == MY_IDX);
      ref_now  = ctl.mark & sel;
      age_base = (ctl.fill && sel) ? '0 : age_ff;
      age_in   = {ref_now, age_base[AGE_BITS-1:1]};
      page_in  = (ctl.fill && sel) ? ctl.page : page_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff      <= '0;
         age_ff       <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         if (ctl.commit) begin
            page_ff <= page_in;
            age_ff  <= age_in;
         end
         if (ctl.shift) begin
            tok_ff.valid <= tok_in_w.valid;
         end
      end
      if (ctl.shift) begin
         tok_ff.page      <= tok_in_w.page;
         tok_ff.hit       <= tok_in_w.hit;
         tok_ff.hit_idx   <= tok_in_w.hit_idx;
         tok_ff.empty     <= tok_in_w.empty;
         tok_ff.empty_idx <= tok_in_w.empty_idx;
         tok_ff.old       <= tok_in_w.old;
         tok_ff.old_age   <= tok_in_w.old_age;
         tok_ff.old_idx   <= tok_in_w.old_idx;
         tok_ff.old_page  <= tok_in_w.old_page;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/apr_ctrl.sv =====
// ----------------------------------------------------------------------------
// apr_ctrl
// Launches a search record into the frame chain, turns the finished record
// into a frame update, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aging_page_replacement_defines.svh"

module apr_ctrl #(
   parameter int NUM_FRAMES = 8,
   parameter int AGE_BITS   = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [apr_pkg::PAGE_W-1:0]  req_page,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_hit,
   output logic                             rsp_fault,
   output logic [apr_pkg::FRAME_W-1:0]      rsp_frame,
   output logic                             rsp_evicted_valid,
   output logic [apr_pkg::PAGE_W-1:0]       rsp_evicted_page,
   output logic [apr_pkg::PAGE_W*2+AGE_BITS+3*$clog2(NUM_FRAMES)+3:0] tok_first,
   input  wire logic [apr_pkg::PAGE_W*2+AGE_BITS+3*$clog2(NUM_FRAMES)+3:0] tok_last,
   output logic [apr_pkg::PAGE_W+$clog2(NUM_FRAMES)+3:0]             upd
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam int EXT_W = (IDX_W > apr_pkg::FRAME_W) ? IDX_W : apr_pkg::FRAME_W;

   typedef struct packed {
      logic                      valid;
      logic [apr_pkg::PAGE_W-1:0] page;
      logic                      hit;
      logic [IDX_W-1:0]          hit_idx;
      logic                      empty;
      logic [IDX_W-1:0]          empty_idx;
      logic                      old;
      logic [AGE_BITS-1:0]       old_age;
      logic [IDX_W-1:0]          old_idx;
      logic [apr_pkg::PAGE_W-1:0] old_page;
   } tok_type;

   typedef struct packed {
      logic                      shift;
      logic                      commit;
      logic                      fill;
      logic                      mark;
      logic [IDX_W-1:0]          target;
      logic [apr_pkg::PAGE_W-1:0] page;
   } upd_type;

   apr_pkg::state_type          state_ff;
   apr_pkg::state_type          state_in;
   tok_type                     tok_start;
   tok_type                     tok_end;
   upd_type                     ctl;
   logic                        accept;
   logic                        commit;
   logic                        busy_page;
   logic [EXT_W-1:0]            tgt_ext;
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic                        rsp_fault_ff;
   logic [apr_pkg::FRAME_W-1:0] rsp_frame_ff;
   logic                        rsp_ev_ff;
   logic [apr_pkg::PAGE_W-1:0]  rsp_evp_ff;
   logic                        rsp_hit_in;
   logic                        rsp_fault_in;
   logic [apr_pkg::FRAME_W-1:0] rsp_frame_in;
   logic                        rsp_ev_in;
   logic [apr_pkg::PAGE_W-1:0]  rsp_evp_in;

   assign tok_end   = tok_last;
   assign tok_first = tok_start;
   assign upd       = ctl;

   assign req_stall = (state_ff != apr_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // Retire the record once the output register is free or draining.
   assign commit    = (state_ff == apr_pkg::ST_SCAN) && tok_end.valid &&
                      (!rsp_valid_ff || !rsp_stall);
   assign busy_page = (tok_end.page != '0);

   always_comb begin
      tok_start       = '0;
      tok_start.valid = accept;
      tok_start.page  = req_page;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apr_pkg::ST_IDLE: if (accept) state_in = apr_pkg::ST_SCAN;
         apr_pkg::ST_SCAN: if (commit) state_in = apr_pkg::ST_IDLE;
         default:          state_in = apr_pkg::ST_IDLE;
      endcase
   end

   // Frame update and result decode.
   always_comb begin
      ctl          = '0;
      ctl.shift    = !(tok_end.valid && !commit);
      ctl.commit   = commit;
      ctl.page     = tok_end.page;
      rsp_hit_in   = 1'b0;
      rsp_fault_in = 1'b0;
      rsp_ev_in    = 1'b0;
      rsp_evp_in   = '0;
      if (busy_page) begin
         ctl.mark = 1'b1;
         if (tok_end.hit) begin
            ctl.target = tok_end.hit_idx;
            rsp_hit_in = 1'b1;
         end else if (tok_end.empty) begin
            ctl.fill     = 1'b1;
            ctl.target   = tok_end.empty_idx;
            rsp_fault_in = 1'b1;
         end else begin
            ctl.fill     = 1'b1;
            ctl.target   = tok_end.old_idx;
            rsp_fault_in = 1'b1;
            rsp_ev_in    = 1'b1;
            rsp_evp_in   = tok_end.old_page;
         end
      end
      tgt_ext      = EXT_W'(ctl.target);
      rsp_frame_in = tgt_ext[apr_pkg::FRAME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff   <= rsp_hit_in;
         rsp_fault_ff <= rsp_fault_in;
         rsp_frame_ff <= rsp_frame_in;
         rsp_ev_ff    <= rsp_ev_in;
         rsp_evp_ff   <= rsp_evp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = rsp_evp_ff;

   `APR_NEVER(a_hit_and_fault, clock, reset, rsp_valid_ff && rsp_hit_ff && rsp_fault_ff, "hit and fault together")
   `APR_ASSERT(a_evict_needs_fault, clock, reset, rsp_valid_ff && rsp_ev_ff |-> rsp_fault_ff, "eviction without fault")
   `APR_ASSERT(a_evict_page_nonzero, clock, reset, rsp_valid_ff |-> (rsp_ev_ff == (rsp_evp_ff != '0)), "evicted page mismatch")
   `APR_ASSERT(a_record_only_in_scan, clock, reset, tok_end.valid |-> (state_ff == apr_pkg::ST_SCAN), "search record outside scan")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for aging_page_replacement: page accesses go in under
// random bursts and gaps, results come out under a varying stall pattern with
// long hold-offs, and every result is compared with a frame-table predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int NUM_FRAMES   = 8;
   localparam int AGE_BITS     = 8;
   localparam int LATENCY      = NUM_FRAMES + 1;
   localparam int RANDOM_ITEMS = 1300;
   localparam int HOLD_CYCLES  = 300;
   // Room for the slowest case per item (block, longest gap, stall stretches)
   // plus the holds, taken many times over
   localparam int LIMIT_CYCLES = 500000;

   typedef struct packed {
      logic                        hit;
      logic                        fault;
      logic [apr_pkg::FRAME_W-1:0] frame;
      logic                        evicted_valid;
      logic [apr_pkg::PAGE_W-1:0]  evicted_page;
   } access_result_type;

   class replacement_scoreboard;
      logic [apr_pkg::PAGE_W-1:0] resident[NUM_FRAMES];
      logic                       referenced[NUM_FRAMES];
      logic [AGE_BITS-1:0]        age[NUM_FRAMES];
      access_result_type          expected_q[$];
      int errors, accesses, results, hits, fills, replacements, zero_pages;

      function new();
         for (int i = 0; i < NUM_FRAMES; i++) begin
            resident[i]   = '0;
            referenced[i] = 1'b0;
            age[i]        = '0;
         end
         errors = 0; accesses = 0; results = 0;
         hits = 0; fills = 0; replacements = 0; zero_pages = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Predict the result of one accepted access, then apply the aging tick.
      function void note_access(logic [apr_pkg::PAGE_W-1:0] pg);
         access_result_type r;
         bit found, has_empty, has_old;
         int hit_idx, empty_idx, old_idx, tgt;
         logic [AGE_BITS-1:0] old_age;
         r = '0;
         found = 0; has_empty = 0; has_old = 0;
         hit_idx = 0; empty_idx = 0; old_idx = 0; old_age = '0;
         accesses++;
         if (pg == '0) begin
            zero_pages++;
         end else begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
               if (resident[i] == '0) begin
                  has_empty = 1;
                  empty_idx = i;
               end else begin
                  if (!has_old || age[i] < old_age) begin
                     has_old = 1;
                     old_age = age[i];
                     old_idx = i;
                  end
                  if (resident[i] == pg) begin
                     found   = 1;
                     hit_idx = i;
                  end
               end
            end
            if (found) begin
               referenced[hit_idx] = 1'b1;
               r.hit   = 1'b1;
               r.frame = apr_pkg::FRAME_W'(hit_idx);
               hits++;
            end else begin
               tgt     = has_empty ? empty_idx : old_idx;
               r.fault = 1'b1;
               r.frame = apr_pkg::FRAME_W'(tgt);
               if (has_empty) begin
                  fills++;
               end else begin
                  r.evicted_valid = 1'b1;
                  r.evicted_page  = resident[tgt];
                  replacements++;
               end
               resident[tgt]   = pg;
               referenced[tgt] = 1'b1;
               age[tgt]        = '0;
            end
         end
         for (int i = 0; i < NUM_FRAMES; i++) begin
            age[i]        = {referenced[i], age[i][AGE_BITS-1:1]};
            referenced[i] = 1'b0;
         end
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH result %0d: %s", results, msg);
         errors++;
      endtask

      task check_result(access_result_type got);
         access_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no access outstanding");
            return;
         end
         want = expected_q.pop_front();
         if (got.hit !== want.hit)
            report_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
         if (got.fault !== want.fault)
            report_mismatch($sformatf("fault got %0b want %0b", got.fault, want.fault));
         if (got.frame !== want.frame)
            report_mismatch($sformatf("frame got %0d want %0d", got.frame, want.frame));
         if (got.evicted_valid !== want.evicted_valid)
            report_mismatch($sformatf("evicted_valid got %0b want %0b",
                                      got.evicted_valid, want.evicted_valid));
         if (got.evicted_page !== want.evicted_page)
            report_mismatch($sformatf("evicted_page got %0h want %0h",
                                      got.evicted_page, want.evicted_page));
         results++;
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [apr_pkg::PAGE_W-1:0]  req_page;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_hit;
   logic                        rsp_fault;
   logic [apr_pkg::FRAME_W-1:0] rsp_frame;
   logic                        rsp_evicted_valid;
   logic [apr_pkg::PAGE_W-1:0]  rsp_evicted_page;

   replacement_scoreboard sb = new();
   int cycles = 0;
   int holds_done = 0;

   aging_page_replacement #(
      .NUM_FRAMES(NUM_FRAMES),
      .AGE_BITS  (AGE_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_page         (req_page),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_fault        (rsp_fault),
      .rsp_frame        (rsp_frame),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_page (rsp_evicted_page)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("tb failed");
         $finish;
      end
   end

   // Offer one access and hold it until the transfer.
   task send_access(input logic [apr_pkg::PAGE_W-1:0] pg);
      @(negedge clock);
      req_valid <= 1'b1;
      req_page  <= pg;
      do @(posedge clock); while (req_stall);
      sb.note_access(pg);
   endtask

   task idle_sender(input int n);
      if (n == 0) return;
      @(negedge clock);
      req_valid <= 1'b0;
      req_page  <= 8'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   function automatic logic [apr_pkg::PAGE_W-1:0] pick_page(int base, int ws);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 72) return apr_pkg::PAGE_W'(base + $urandom_range(0, ws - 1));
      return apr_pkg::PAGE_W'($urandom_range(1, 255));
   endfunction

   // Result side: stall pattern of its own, with two long hold-offs.
   initial begin
      int mode, len, period, duty, k;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ((holds_done == 0 && sb.accesses >= 300) ||
             (holds_done == 1 && sb.accesses >= 1000)) begin
            holds_done++;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode   = $urandom_range(0, 2);
         len    = $urandom_range(10, 80);
         period = $urandom_range(2, 9);
         duty   = $urandom_range(1, period - 1);
         k      = 0;
         repeat (len) begin
            @(negedge clock);
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 99) < 40);
               end
               default: begin
                  rsp_stall <= ((k % period) < duty);
               end
            endcase
            k++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(access_result_type'{rsp_hit, rsp_fault, rsp_frame,
                                             rsp_evicted_valid, rsp_evicted_page});
   end

   initial begin
      int directed[$];
      int sent, burst, base, ws;
      directed = '{0, 1, 255, 1, 128, 127, 85, 170, 51, 204, 204, 1, 15, 240,
                   0, 255, 15, 2, 3, 4, 255, 1};
      reset     = 1'b1;
      req_valid = 1'b0;
      req_page  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill all frames, hit, replace, and page zero on empty and full tables
      foreach (directed[i]) begin
         send_access(apr_pkg::PAGE_W'(directed[i]));
         if (i % 5 == 4) idle_sender($urandom_range(1, 6));
      end

      sent = 0;
      base = 1;
      ws   = 8;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 100 == 0) begin
            ws   = $urandom_range(4, 14);
            base = $urandom_range(1, 256 - ws);
         end
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            send_access(pick_page(base, ws));
            sent++;
         end
         if ($urandom_range(0, 1))
            idle_sender($urandom_range(1, 12));
      end
      idle_sender(1);

      while (sb.pending() != 0) @(posedge clock);
      repeat (3 * LATENCY) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

      $display("ran %0d accesses: %0d hits, %0d fills, %0d replacements, %0d zero pages",
               sb.accesses, sb.hits, sb.fills, sb.replacements, sb.zero_pages);
      $display("checked %0d results with %0d long result hold-offs, %0d mismatches",
               sb.results, holds_done, sb.errors);
      if (sb.errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

`default_nettype wire
